@@ rtl/rstt_pkg.sv @@
// Package: shared constants, operation codes and controller/datapath structs.
`timescale 1ns / 1ps
package rstt_pkg;

  localparam int READER_SLOTS = 16;
  localparam int IDX_W        = $clog2(READER_SLOTS);
  localparam int CNT_W        = $clog2(READER_SLOTS + 1);
  localparam int SUM_W        = IDX_W + 1;
  localparam int TXN_W        = 64;
  localparam int FUNC_W       = 3;
  localparam int SLOT_W       = 4;
  localparam int STAT_W       = 2;

  localparam logic [FUNC_W-1:0] FN_START  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_END    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FREE   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic capture;
    logic scan_run;
    logic rd_slot;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic cache_valid;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/rstt_ctrl.sv @@
// Controller: sequences capture, slot scan, slot read and commit of each request.
`timescale 1ns / 1ps
module rstt_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [rstt_pkg::FUNC_W-1:0]  in_func,
  output logic                         in_ready,
  input  rstt_pkg::sts_t               sts,
  output rstt_pkg::cmd_t               cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD_RD,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.scan_run = 1'b0;
    cmd.rd_slot  = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_func == rstt_pkg::FN_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (in_func == rstt_pkg::FN_QUERY) begin
            state_nxt = sts.cache_valid ? S_COMMIT : S_SCAN;
          end else if (in_func == rstt_pkg::FN_UPDATE) begin
            state_nxt = S_UPD_RD;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_UPD_RD: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/rstt_dp.sv @@
// Datapath: slot table, lock, search start, oldest cache, scan unit and result register.
`timescale 1ns / 1ps
module rstt_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rstt_pkg::FUNC_W-1:0]  in_func,
  input  logic [rstt_pkg::SLOT_W-1:0]  in_slot,
  input  logic [rstt_pkg::TXN_W-1:0]   in_head_txn,
  input  rstt_pkg::cmd_t               cmd,
  output rstt_pkg::sts_t               sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [rstt_pkg::STAT_W-1:0]  out_status,
  output logic [rstt_pkg::SLOT_W-1:0]  out_slot_out,
  output logic [rstt_pkg::TXN_W-1:0]   out_oldest_txn
);

  localparam int N     = rstt_pkg::READER_SLOTS;
  localparam int IDX_W = rstt_pkg::IDX_W;
  localparam int CNT_W = rstt_pkg::CNT_W;
  localparam int SUM_W = rstt_pkg::SUM_W;
  localparam int TXN_W = rstt_pkg::TXN_W;

  logic [rstt_pkg::FUNC_W-1:0] func_r;
  logic [rstt_pkg::SLOT_W-1:0] slot_r;
  logic [TXN_W-1:0]            head_r;
  logic                        wa_r;
  logic [IDX_W-1:0]            start_r;
  logic [TXN_W-1:0]            cache_r;
  logic [TXN_W-1:0]            min_r;
  logic                        found_r;
  logic [IDX_W-1:0]            chosen_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        chk_vld_r;
  logic [IDX_W-1:0]            chk_slot_r;

  logic [TXN_W-1:0]            mem [N];
  logic [N-1:0]                valid_r;
  logic [TXN_W-1:0]            rd_data_r;
  logic                        rd_vld_r;

  logic                        out_valid_r;
  logic [rstt_pkg::STAT_W-1:0] out_status_r;
  logic [rstt_pkg::SLOT_W-1:0] out_slot_r;
  logic [TXN_W-1:0]            out_oldest_r;

  logic                        slot_ok;
  logic [IDX_W-1:0]            slot_idx;
  logic [SUM_W-1:0]            scan_sum;
  logic [IDX_W-1:0]            scan_addr;
  logic                        issue;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [TXN_W-1:0]            rd_val;
  logic [IDX_W-1:0]            chosen_inc;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic                        vld_clr;
  logic                        wa_nxt;
  logic [IDX_W-1:0]            start_nxt;
  logic [TXN_W-1:0]            cache_nxt;
  logic [rstt_pkg::STAT_W-1:0] res_status;
  logic [rstt_pkg::SLOT_W-1:0] res_slot;
  logic [TXN_W-1:0]            res_oldest;

  assign slot_ok  = (32'(slot_r) < N);
  assign slot_idx = IDX_W'(slot_r);

  assign scan_sum = SUM_W'(start_r) + SUM_W'(cnt_r);
  always_comb begin
    if (func_r == rstt_pkg::FN_ALLOC) begin
      if (scan_sum >= SUM_W'(N)) begin
        scan_addr = IDX_W'(scan_sum - SUM_W'(N));
      end else begin
        scan_addr = IDX_W'(scan_sum);
      end
    end else begin
      scan_addr = cnt_r[IDX_W-1:0];
    end
  end

  assign issue   = cmd.scan_run && (cnt_r != CNT_W'(N));
  assign rd_en   = issue || (cmd.rd_slot && slot_ok);
  assign rd_addr = cmd.rd_slot ? slot_idx : scan_addr;
  assign rd_val  = rd_vld_r ? rd_data_r : '0;

  assign chosen_inc = (chosen_r == IDX_W'(N - 1)) ? '0 : chosen_r + 1'b1;

  assign sts.scan_done   = (cnt_r == CNT_W'(N)) && !chk_vld_r;
  assign sts.cache_valid = (cache_r != '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = chosen_r;
    vld_clr    = 1'b0;
    wa_nxt     = wa_r;
    start_nxt  = start_r;
    cache_nxt  = cache_r;
    res_status = rstt_pkg::ST_OK;
    res_slot   = '0;
    res_oldest = '0;
    unique case (func_r)
      rstt_pkg::FN_START: begin
        if (wa_r) begin
          res_status = rstt_pkg::ST_BUSY;
        end else begin
          wa_nxt = 1'b1;
        end
      end
      rstt_pkg::FN_END: wa_nxt = 1'b0;
      rstt_pkg::FN_ALLOC: begin
        if (found_r) begin
          mem_we    = 1'b1;
          start_nxt = chosen_inc;
          res_slot  = rstt_pkg::SLOT_W'(chosen_r);
        end else begin
          res_status = rstt_pkg::ST_FULL;
        end
      end
      rstt_pkg::FN_UPDATE: begin
        mem_wa = slot_idx;
        if (slot_ok && (rd_val != head_r)) begin
          mem_we    = 1'b1;
          cache_nxt = '0;
        end
      end
      rstt_pkg::FN_FREE: begin
        mem_wa = slot_idx;
        if (slot_ok) begin
          vld_clr   = 1'b1;
          cache_nxt = '0;
        end
      end
      rstt_pkg::FN_QUERY: begin
        if (cache_r != '0) begin
          res_oldest = cache_r;
        end else begin
          res_oldest = min_r;
          cache_nxt  = min_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[mem_wa] <= head_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      wa_r        <= 1'b0;
      start_r     <= '0;
      cache_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        cnt_r     <= '0;
        chk_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else if (cmd.scan_run) begin
        chk_vld_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (chk_vld_r && (func_r == rstt_pkg::FN_ALLOC) && !found_r && (rd_val == '0)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (mem_we) begin
          valid_r[mem_wa] <= 1'b1;
        end
        if (vld_clr) begin
          valid_r[mem_wa] <= 1'b0;
        end
        wa_r    <= wa_nxt;
        start_r <= start_nxt;
        cache_r <= cache_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      slot_r <= in_slot;
      head_r <= in_head_txn;
      min_r  <= in_head_txn;
    end else if (cmd.scan_run && chk_vld_r) begin
      if ((func_r == rstt_pkg::FN_ALLOC) && !found_r && (rd_val == '0)) begin
        chosen_r <= chk_slot_r;
      end
      if ((func_r == rstt_pkg::FN_QUERY) && (rd_val != '0) && (rd_val < min_r)) begin
        min_r <= rd_val;
      end
    end
    if (issue) begin
      chk_slot_r <= scan_addr;
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_oldest_r <= res_oldest;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_oldest_txn = out_oldest_r;

endmodule

@@ rtl/reader_slot_txn_tracker_top.sv @@
// Allocate and uncached query scan the slot table, update first reads its slot and all
// others go to commit; a new request is taken in the cycle after the result is loaded.
// Scan length is set by the slot table's single registered read port, one slot a cycle.
// The result register frees the input side while a result waits to be taken.
// Synchronous active-low reset clears the lock, search start, cache and slot valid bits.
`timescale 1ns / 1ps
module reader_slot_txn_tracker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rstt_pkg::FUNC_W-1:0]  in_func,
  input  logic [rstt_pkg::SLOT_W-1:0]  in_slot,
  input  logic [rstt_pkg::TXN_W-1:0]   in_head_txn,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rstt_pkg::STAT_W-1:0]  out_status,
  output logic [rstt_pkg::SLOT_W-1:0]  out_slot_out,
  output logic [rstt_pkg::TXN_W-1:0]   out_oldest_txn
);

  rstt_pkg::cmd_t cmd;
  rstt_pkg::sts_t sts;

  rstt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rstt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_head_txn    (in_head_txn),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_oldest_txn (out_oldest_txn)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in progress");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != rstt_pkg::ST_OK)) |-> (out_slot_out == '0))
    else $error("slot reported with failing status");

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without commit");
`endif

endmodule

@@ test/reader_slot_txn_tracker_top_test.sv @@
// Testbench for the reader slot tracker: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps
module reader_slot_txn_tracker_top_test;
  import rstt_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int ITEMS_PER_PHASE = 185;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [TXN_W-1:0]  oldest;
  } tracker_result_t;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [SLOT_W-1:0] idx;
    logic [TXN_W-1:0]  head;
    int                reps;
    bit                typed;
    tracker_result_t   want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func = FN_START;
  logic [SLOT_W-1:0]  in_slot = '0;
  logic [TXN_W-1:0]   in_head_txn = 64'd1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [SLOT_W-1:0]  out_slot_out;
  logic [TXN_W-1:0]   out_oldest_txn;

  // predictor state
  logic               write_lock;
  logic [IDX_W-1:0]   next_search;
  logic [TXN_W-1:0]   slot_txn [READER_SLOTS];
  logic [TXN_W-1:0]   oldest_cache;

  tracker_result_t    pending_results [$];
  tracker_result_t    rx_want;
  dir_row_t           dir_rows [$];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;

  reader_slot_txn_tracker_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_head_txn    (in_head_txn),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_oldest_txn (out_oldest_txn)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic tracker_result_t predict_request(input logic [FUNC_W-1:0] op,
                                                      input logic [SLOT_W-1:0] idx,
                                                      input logic [TXN_W-1:0]  head);
    tracker_result_t  r;
    logic [IDX_W-1:0] s;
    logic [TXN_W-1:0] m;
    bit               found;
    r = '0;
    found = 1'b0;
    case (op)
      FN_START: begin
        if (write_lock) r.status = ST_BUSY;
        else write_lock = 1'b1;
      end
      FN_END: write_lock = 1'b0;
      FN_ALLOC: begin
        for (int i = 0; i < READER_SLOTS && !found; i++) begin
          s = IDX_W'((int'(next_search) + i) % READER_SLOTS);
          if (slot_txn[s] == '0) begin
            slot_txn[s] = head;
            next_search = IDX_W'((int'(s) + 1) % READER_SLOTS);
            r.slot = SLOT_W'(s);
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_FULL;
      end
      FN_UPDATE: begin
        if (idx < READER_SLOTS && slot_txn[idx] != head) begin
          slot_txn[idx] = head;
          oldest_cache = '0;
        end
      end
      FN_FREE: begin
        if (idx < READER_SLOTS) begin
          slot_txn[idx] = '0;
          oldest_cache = '0;
        end
      end
      FN_QUERY: begin
        if (oldest_cache != '0) begin
          r.oldest = oldest_cache;
        end else begin
          m = head;
          for (int i = 0; i < READER_SLOTS; i++)
            if (slot_txn[i] != '0 && slot_txn[i] < m) m = slot_txn[i];
          oldest_cache = m;
          r.oldest = m;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [TXN_W-1:0] pick_txn();
    logic [TXN_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = TXN_W'($urandom_range(1, 40));
      1: v = '1 - TXN_W'($urandom_range(0, 40));
      default: v = {$urandom, $urandom};
    endcase
    if (v == '0) v = 64'd1;
    return v;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] op, input logic [SLOT_W-1:0] idx,
                         input logic [TXN_W-1:0] head, input int reps, input bit typed,
                         input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] sl,
                         input logic [TXN_W-1:0] old);
    dir_row_t row;
    row.op = op;
    row.idx = idx;
    row.head = head;
    row.reps = reps;
    row.typed = typed;
    row.want = '{st, sl, old};
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [SLOT_W-1:0] idx,
                              input logic [TXN_W-1:0] head, input bit typed,
                              input tracker_result_t want);
    tracker_result_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_slot <= idx;
    in_head_txn <= head;
    do @(posedge clk); while (!in_ready);
    r = predict_request(op, idx, head);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status %0d slot %0d oldest %h", $time,
                   out_status, out_slot_out, out_oldest_txn);
          error_count++;
        end else begin
          rx_want = pending_results.pop_front();
          if (out_status !== rx_want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, rx_want.status, out_status);
            error_count++;
          end
          if (out_slot_out !== rx_want.slot) begin
            $display("%0t: slot_out expected %0d actual %0d", $time, rx_want.slot,
                     out_slot_out);
            error_count++;
          end
          if (out_oldest_txn !== rx_want.oldest) begin
            $display("%0t: oldest_txn expected %h actual %h", $time, rx_want.oldest,
                     out_oldest_txn);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int                send_pcts [4];
    int                recv_pcts [4];
    int                pick;
    logic [FUNC_W-1:0] op;
    logic [SLOT_W-1:0] idx;
    logic [TXN_W-1:0]  head;
    send_pcts = '{0, 73, 0, 19};
    recv_pcts = '{0, 0, 73, 19};
    write_lock = 1'b0;
    next_search = '0;
    oldest_cache = '0;
    foreach (slot_txn[k]) slot_txn[k] = '0;

    add_row(FN_QUERY,  4'd0,  64'd5, 1, 1, ST_OK,   4'd0, 64'd5);
    add_row(FN_QUERY,  4'd0,  64'd3, 1, 1, ST_OK,   4'd0, 64'd5);
    add_row(FN_START,  4'd0,  64'd1, 1, 1, ST_OK,   4'd0, 64'd0);
    add_row(FN_START,  4'd0,  64'd1, 1, 1, ST_BUSY, 4'd0, 64'd0);
    add_row(FN_END,    4'd0,  64'd1, 1, 1, ST_OK,   4'd0, 64'd0);
    add_row(FN_END,    4'd0,  64'd1, 1, 1, ST_OK,   4'd0, 64'd0);
    add_row(FN_ALLOC,  4'd0,  '1,    1, 1, ST_OK,   4'd0, 64'd0);
    add_row(FN_ALLOC,  4'd15, 64'd1, 1, 1, ST_OK,   4'd1, 64'd0);
    add_row(FN_UPDATE, 4'd1,  64'd1, 1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_QUERY,  4'd0,  64'd9, 1, 1, ST_OK,   4'd0, 64'd5);
    add_row(FN_UPDATE, 4'd15, 64'd7, 1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_QUERY,  4'd0,  '1,    1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_FREE,   4'd1,  64'd1, 1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_QUERY,  4'd0,  64'h8000_0000_0000_0000, 1, 0, ST_OK, 4'd0, 64'd0);
    add_row(FN_ALLOC,  4'd10, 64'h5555_5555_5555_5555, 14, 0, ST_OK, 4'd0, 64'd0);
    add_row(FN_ALLOC,  4'd0,  64'd3, 1, 1, ST_FULL, 4'd0, 64'd0);
    add_row(FN_QUERY,  4'd0,  '1,    1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_FREE,   4'd9,  64'd1, 1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_UPDATE, 4'd3,  64'hAAAA_AAAA_AAAA_AAAA, 1, 0, ST_OK, 4'd0, 64'd0);
    add_row(FN_ALLOC,  4'd0,  64'd2, 1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_QUERY,  4'd0,  '1,    1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_FREE,   4'd0,  '1,    1, 0, ST_OK,   4'd0, 64'd0);
    add_row(FN_QUERY,  4'd0,  '1,    1, 0, ST_OK,   4'd0, 64'd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k])
      repeat (dir_rows[k].reps)
        send_request(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].head, dir_rows[k].typed,
                     dir_rows[k].want);

    for (int ph = 0; ph < 4; ph++) begin
      // hold until the table has answered every request
      wait_drained();
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        idx = SLOT_W'($urandom_range(0, READER_SLOTS - 1));
        head = pick_txn();
        if (pick < 10) op = FN_START;
        else if (pick < 20) op = FN_END;
        else if (pick < 50) op = FN_ALLOC;
        else if (pick < 65) op = FN_UPDATE;
        else if (pick < 80) op = FN_FREE;
        else op = FN_QUERY;
        if (op == FN_UPDATE && slot_txn[idx] != '0 && $urandom_range(0, 3) == 0)
          head = slot_txn[idx];
        send_request(op, idx, head, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rstt_pkg.sv
rtl/rstt_ctrl.sv
rtl/rstt_dp.sv
rtl/reader_slot_txn_tracker_top.sv
test/reader_slot_txn_tracker_top_test.sv
